// ===== sv/sdrrip_pkg.sv =====
// Shared types and constants for the stream-aware DRRIP replacement block.
// No dependencies.
package sdrrip_pkg;
  localparam int unsigned SigW = 6;
  localparam logic [9:0] SelMid = 10'd512;
  localparam logic [9:0] SelMax = 10'd1023;
  localparam logic [2:0] StreamMax = 3'd7;
  localparam logic [1:0] RrpvMax = 2'd3;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef struct packed {
    logic        op;
    logic [15:0] set_index;
    logic [4:0]  way_index;
    logic [31:0] valid_mask;
    logic [63:0] phys_address;
    logic [5:0]  sig;
    logic        hit;
    logic        draw_zero;
    logic        all_valid;
    logic [4:0]  first_invalid;
  } job_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] inserted_rrpv;
    logic [2:0] stream_count;
    logic [1:0] signature_counter;
    logic [9:0] selector;
  } result_t;

  function automatic logic [5:0] make_sig(input logic [17:0] pc);
    logic [17:0] x;
    begin
      x = pc ^ (pc >> 6) ^ (pc >> 12);
      return x[5:0];
    end
  endfunction
endpackage

// ===== sv/sdrrip_front.sv =====
// Front end: accepts items, derives the signature and the first invalid way.
// Depends on sdrrip_pkg.
module sdrrip_front #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [119:0]         in_data,
  input  logic                 in_user,
  output logic                 q_valid,
  input  logic                 q_ready,
  output sdrrip_pkg::job_t     q_job
);
  import sdrrip_pkg::*;
  job_t j;
  logic [10:0] si;
  logic [3:0] wi;
  logic [15:0] vm;
  always_comb begin
    si = in_data[11:1];
    wi = in_data[15:12];
    vm = in_data[31:16];
    j = '0;
    j.op = in_data[0];
    j.set_index = 16'(si) & 16'(NUM_SETS - 1);
    j.way_index = 5'(wi) & 5'(NUM_WAYS - 1);
    j.valid_mask = 32'(vm);
    j.phys_address = in_data[95:32];
    j.sig = make_sig(in_data[113:96]);
    j.hit = in_user;
    j.draw_zero = (in_data[118:114] == 5'd0);
    j.all_valid = 1'b1;
    j.first_invalid = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!j.valid_mask[w]) begin
        j.all_valid = 1'b0;
        j.first_invalid = 5'(w);
      end
    end
  end
  // two-entry queue
  job_t q0, q1;
  logic [1:0] cnt;
  assign in_ready = (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_job = q0;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if ((in_valid && in_ready) && !(q_valid && q_ready)) begin
        if (cnt == 2'd0) q0 <= j; else q1 <= j;
        cnt <= cnt + 2'd1;
      end else if (!(in_valid && in_ready) && (q_valid && q_ready)) begin
        q0 <= q1;
        cnt <= cnt - 2'd1;
      end else if (in_valid && in_ready) begin
        if (cnt == 2'd1) q0 <= j; else begin q0 <= q1; q1 <= j; end
      end
    end
  end
endmodule

// ===== sv/sdrrip_back.sv =====
// Back end: reads per-set state, applies a victim pick or an update,
// writes back and holds the result. Depends on sdrrip_pkg.
module sdrrip_back #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int LEADERS_PER_POLICY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sdrrip_pkg::job_t     q_job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdrrip_pkg::result_t  out_res
);
  import sdrrip_pkg::*;
  localparam int SW = $clog2(NUM_SETS);
  localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SIG   = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;
  state_t state;

  logic [2*NUM_WAYS-1:0] rrpv_mem [NUM_SETS];
  logic [SigW*NUM_WAYS-1:0] sig_mem [NUM_SETS];
  logic [130:0] set_mem [NUM_SETS];
  logic [1:0] outcome [64];
  logic [9:0] selector;
  logic [SW-1:0] clr;

  job_t job;
  logic [2*NUM_WAYS-1:0] rrpv_rd;
  logic [SigW*NUM_WAYS-1:0] sig_rd;
  logic [130:0] set_rd;
  logic [1:0] oc_sig_rd, oc_old_rd;
  result_t res;

  logic [SW-1:0] set_a;
  assign set_a = job.set_index[SW-1:0];
  assign q_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_res = res;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      rrpv_rd <= rrpv_mem[q_job.set_index[SW-1:0]];
      sig_rd <= sig_mem[q_job.set_index[SW-1:0]];
      set_rd <= set_mem[q_job.set_index[SW-1:0]];
    end
  end

  logic [2*NUM_WAYS-1:0] rrpv_new;
  logic [SigW*NUM_WAYS-1:0] sig_new;
  logic [130:0] set_new;
  logic [1:0] top, add, ins, cnt_after;
  logic [3:0] vic;
  logic [63:0] stride, prev_addr, prev_stride;
  logic [2:0] sc;
  logic lead_s, lead_b;
  logic [5:0] old_sig;
  logic [9:0] sel_n;
  logic [1:0] oc_sig, oc_old;
  logic upd_outcome_up, upd_outcome_dn;
  logic [WW-1:0] wy;

  always_ff @(posedge clk) begin
    if (state == S_SIG) begin
      oc_sig_rd <= outcome[job.sig];
      oc_old_rd <= outcome[old_sig];
    end
  end

  always_comb begin
    wy = job.way_index[WW-1:0];
    prev_addr = set_rd[63:0];
    prev_stride = set_rd[127:64];
    stride = job.phys_address - prev_addr;
    lead_s = job.set_index < 16'(LEADERS_PER_POLICY);
    lead_b = (job.set_index >= 16'(NUM_SETS / 2)) &&
             (32'(job.set_index) < 32'(NUM_SETS / 2 + LEADERS_PER_POLICY));
    old_sig = sig_rd[wy*SigW +: SigW];
    rrpv_new = rrpv_rd;
    sig_new = sig_rd;
    set_new = set_rd;
    sel_n = selector;
    ins = 2'd0;
    vic = 4'd0;
    top = 2'd0;
    add = 2'd0;
    sc = set_rd[130:128];
    upd_outcome_up = 1'b0;
    upd_outcome_dn = 1'b0;
    if (job.op == OP_VICTIM) begin
      if (!job.all_valid) begin
        vic = job.first_invalid[3:0];
      end else begin
        for (int w = 0; w < NUM_WAYS; w++)
          if (rrpv_rd[2*w +: 2] > top) top = rrpv_rd[2*w +: 2];
        add = RrpvMax - top;
        for (int w = 0; w < NUM_WAYS; w++)
          rrpv_new[2*w +: 2] = rrpv_rd[2*w +: 2] + add;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
          if (rrpv_new[2*w +: 2] == RrpvMax) vic = 4'(w);
      end
    end else begin
      sig_new[wy*SigW +: SigW] = job.sig;
      if (prev_stride != 64'd0 && stride == prev_stride) begin
        if (sc < StreamMax) sc = sc + 3'd1;
      end else begin
        sc = 3'd0;
      end
      set_new = {sc, stride, job.phys_address};
      if (job.hit) begin
        ins = 2'd0;
        upd_outcome_up = 1'b1;
        if (lead_s && sel_n < SelMax) sel_n = sel_n + 10'd1;
        if (lead_b && sel_n > 10'd0) sel_n = sel_n - 10'd1;
      end else begin
        if (lead_s) ins = 2'd2;
        else if (lead_b) ins = job.draw_zero ? 2'd2 : 2'd3;
        else if (selector >= SelMid) ins = 2'd2;
        else ins = job.draw_zero ? 2'd2 : 2'd3;
        upd_outcome_dn = 1'b1;
      end
      rrpv_new[wy*2 +: 2] = ins;
    end
    oc_sig = oc_sig_rd;
    oc_old = oc_old_rd;
    if (upd_outcome_up && oc_sig < RrpvMax) oc_sig = oc_sig + 2'd1;
    if (upd_outcome_dn && oc_old > 2'd0) oc_old = oc_old - 2'd1;
    cnt_after = oc_sig;
    if (upd_outcome_dn && old_sig == job.sig) cnt_after = oc_old;
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      rrpv_mem[clr] <= '0;
      sig_mem[clr] <= '0;
      set_mem[clr] <= '0;
      outcome[clr[5:0]] <= '0;
    end else if (state == S_EXEC) begin
      rrpv_mem[set_a] <= rrpv_new;
      sig_mem[set_a] <= sig_new;
      set_mem[set_a] <= set_new;
      if (upd_outcome_up) outcome[job.sig] <= oc_sig;
      if (upd_outcome_dn) outcome[old_sig] <= oc_old;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) job <= q_job;
    if (state == S_EXEC) begin
      res.victim_way <= vic;
      res.inserted_rrpv <= ins;
      res.stream_count <= (job.op == OP_VICTIM) ? set_rd[130:128] : sc;
      res.signature_counter <= cnt_after;
      res.selector <= sel_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      selector <= SelMid;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + SW'(1);
          if (clr == SW'(NUM_SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) state <= S_SIG;
        S_SIG: state <= S_EXEC;
        S_EXEC: begin
          selector <= sel_n;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/ship_stream_drrip_replacement.sv =====
// Top level of the stream-aware DRRIP replacement block.
// Depends on sdrrip_pkg, sdrrip_front and sdrrip_back.
//
// Input stream s_axis: one transfer per request (victim pick or update).
// Output stream m_axis: exactly one result transfer per request, in order.
// After rst the back end sweeps its per-set memories; the front queue
// takes up to two transfers meanwhile, then s_axis_tready drops until
// the sweep ends and results start after it.
// With an idle back end a request leaves the queue with the set memory
// read, then goes through the signature counter read and then the
// read-modify-write, after which its result is valid on m_axis.
// The back end holds one request at a time, so it takes a new request
// only once the last result has been accepted; the chained set memory
// and counter reads and the result state come between two requests.
// The front end queues two requests, so s_axis keeps accepting up to two
// while a result waits for m_axis_tready. A stalled result is held unchanged.
// tlast is not used; hit travels as tuser.
module ship_stream_drrip_replacement #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int LEADERS_PER_POLICY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation, set_index, way_index, valid_mask, phys_address, pc_low,
  // random_draw from bit 0 up
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tuser, // hit
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // victim_way, inserted_rrpv, stream_count, signature_counter, selector
  output logic [23:0]  m_axis_tdata
);
  import sdrrip_pkg::*;
  logic q_valid, q_ready;
  job_t q_job;
  result_t res;

  sdrrip_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_user(s_axis_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  sdrrip_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
                .LEADERS_PER_POLICY(LEADERS_PER_POLICY)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_res(res)
  );

  assign m_axis_tdata = {3'd0, res.selector, res.signature_counter,
                         res.stream_count, res.inserted_rrpv, res.victim_way};
endmodule
